FILE: hdl/cpualu_pkg.sv
`default_nettype none

package cpualu_pkg;

  // Operation codes carried on the command field.
  typedef enum logic [5:0] {
    CMD_ADD   = 6'd0,
    CMD_ADC   = 6'd1,
    CMD_SUB   = 6'd2,
    CMD_SBC   = 6'd3,
    CMD_AND   = 6'd4,
    CMD_XOR   = 6'd5,
    CMD_OR    = 6'd6,
    CMD_CP    = 6'd7,
    CMD_INC   = 6'd8,
    CMD_DEC   = 6'd9,
    CMD_RLC   = 6'd10,
    CMD_RRC   = 6'd11,
    CMD_RL    = 6'd12,
    CMD_RR    = 6'd13,
    CMD_SLA   = 6'd14,
    CMD_SRA   = 6'd15,
    CMD_SWAP  = 6'd16,
    CMD_SRL   = 6'd17,
    CMD_BIT   = 6'd18,
    CMD_RES   = 6'd19,
    CMD_SET   = 6'd20,
    CMD_RLCA  = 6'd21,
    CMD_RRCA  = 6'd22,
    CMD_RLA   = 6'd23,
    CMD_RRA   = 6'd24,
    CMD_DAA   = 6'd25,
    CMD_CPL   = 6'd26,
    CMD_SCF   = 6'd27,
    CMD_CCF   = 6'd28,
    CMD_ADD16 = 6'd29,
    CMD_ADDSP = 6'd30,
    CMD_INC16 = 6'd31,
    CMD_DEC16 = 6'd32
  } cmd_t;

  // Decimal adjust constants.
  localparam logic [7:0] DAA_LIMIT  = 8'h99;
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [3:0] DAA_NIB    = 4'h9;

  // Z, N, H and C flags.
  typedef struct packed {
    logic zero;
    logic subtract;
    logic half;
    logic carry;
  } flags_t;

  // One operation beat as it sits in the input register.
  typedef struct packed {
    logic [5:0]  command;
    logic [7:0]  operand_a;
    logic [7:0]  operand_b;
    logic [2:0]  bit_index;
    logic [15:0] wide_a;
    logic [15:0] wide_b;
    flags_t      flags;
  } op_t;

  // One result beat as it sits in the output register.
  typedef struct packed {
    logic [15:0] result;
    logic        writes_back;
    flags_t      flags;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/cpu_alu_with_flags_core.sv
// Timing: an accepted beat is captured in the input register, passes the ALU, and
//   its result is strobed on out_valid from the result register.
// Throughput: one operation per cycle; busy is always low, set by the input register
//   feeding the result register through a single ALU pass.
// Reset: synchronous active-low rst_n clears both valid bits; no beats are in flight.
`default_nettype none

module cpu_alu_with_flags_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [5:0]  in_command,
  input  wire  [7:0]  in_operand_a,
  input  wire  [7:0]  in_operand_b,
  input  wire  [2:0]  in_bit_index,
  input  wire  [15:0] in_wide_a,
  input  wire  [15:0] in_wide_b,
  input  wire         in_zero_in,
  input  wire         in_subtract_in,
  input  wire         in_half_in,
  input  wire         in_carry_in,
  output logic        out_valid,
  output logic [15:0] out_result,
  output logic        out_writes_back,
  output logic        out_zero_out,
  output logic        out_subtract_out,
  output logic        out_half_out,
  output logic        out_carry_out
);

  logic              accept;
  logic              op_valid_r;
  logic              op_valid_nxt;
  cpualu_pkg::op_t   op_r;
  cpualu_pkg::op_t   op_nxt;
  logic              res_valid_r;
  cpualu_pkg::res_t  res_r;
  cpualu_pkg::res_t  res_nxt;

  // The pipeline never stalls, so a new beat is taken every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register.
  assign op_valid_nxt = accept;
  always_comb begin
    op_nxt = '{command:   in_command,
               operand_a: in_operand_a,
               operand_b: in_operand_b,
               bit_index: in_bit_index,
               wide_a:    in_wide_a,
               wide_b:    in_wide_b,
               flags:     '{zero: in_zero_in, subtract: in_subtract_in,
                            half: in_half_in, carry: in_carry_in}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else begin
      op_valid_r <= op_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_nxt;
    end
  end

  // Single-pass ALU.
  cpualu_exec u_exec (
    .op  (op_r),
    .res (res_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= op_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_result       = res_r.result;
  assign out_writes_back  = res_r.writes_back;
  assign out_zero_out     = res_r.flags.zero;
  assign out_subtract_out = res_r.flags.subtract;
  assign out_half_out     = res_r.flags.half;
  assign out_carry_out    = res_r.flags.carry;

`ifndef ASSERT_OFF
  // Every accepted beat comes out as a result strobe.
  a_accept_to_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("accepted beat did not produce a result strobe");

  // No strobe without a beat in the input register the cycle before.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(op_valid_r))
    else $error("result strobe without a preceding operation");

  // Compare and bit test never write back.
  a_cp_bit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid_r && (op_r.command == cpualu_pkg::CMD_CP
                    || op_r.command == cpualu_pkg::CMD_BIT)) |=> !out_writes_back)
    else $error("compare or bit test marked for write-back");

  // Accumulator rotates always clear the zero flag.
  a_rota_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid_r && (op_r.command == cpualu_pkg::CMD_RLCA
                    || op_r.command == cpualu_pkg::CMD_RRCA
                    || op_r.command == cpualu_pkg::CMD_RLA
                    || op_r.command == cpualu_pkg::CMD_RRA)) |=> !out_zero_out)
    else $error("accumulator rotate left zero flag set");
`endif

endmodule

`default_nettype wire

FILE: hdl/cpualu_exec.sv
`default_nettype none

module cpualu_exec (
  input  var cpualu_pkg::op_t  op,
  output var cpualu_pkg::res_t res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin_add;
  logic        cin_sub;
  logic [8:0]  add_sum;
  logic [4:0]  add_nib;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_nib;
  logic [16:0] w_sum;
  logic [12:0] w_low;
  logic [15:0] sp_sum;
  logic [8:0]  sp_byte;
  logic [4:0]  sp_nib;
  logic [7:0]  bit_mask;
  logic [7:0]  daa_adj;
  logic [7:0]  daa_val;
  logic        daa_carry;

  assign a = op.operand_a;
  assign b = op.operand_b;

  // Carry or borrow in only for the with-carry forms.
  assign cin_add = (op.command == cpualu_pkg::CMD_ADC) ? op.flags.carry : 1'b0;
  assign cin_sub = (op.command == cpualu_pkg::CMD_SBC) ? op.flags.carry : 1'b0;

  // Byte adder and subtractor with nibble carries.
  assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, cin_add};
  assign add_nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_add};
  assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, cin_sub};
  assign sub_nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sub};

  // Sixteen-bit adds: register pair add and stack offset add.
  assign w_sum   = {1'b0, op.wide_a} + {1'b0, op.wide_b};
  assign w_low   = {1'b0, op.wide_a[11:0]} + {1'b0, op.wide_b[11:0]};
  assign sp_sum  = op.wide_a + {{8{b[7]}}, b};
  assign sp_byte = {1'b0, op.wide_a[7:0]} + {1'b0, b};
  assign sp_nib  = {1'b0, op.wide_a[3:0]} + {1'b0, b[3:0]};

  assign bit_mask = 8'(8'h01 << op.bit_index);

  // Decimal adjust after an add or a subtract.
  always_comb begin
    daa_adj   = 8'h00;
    daa_carry = op.flags.carry;
    if (!op.flags.subtract) begin
      if (op.flags.carry || (a > cpualu_pkg::DAA_LIMIT)) begin
        daa_adj   = daa_adj | cpualu_pkg::DAA_HI_ADJ;
        daa_carry = 1'b1;
      end
      if (op.flags.half || (a[3:0] > cpualu_pkg::DAA_NIB)) begin
        daa_adj = daa_adj | cpualu_pkg::DAA_LO_ADJ;
      end
      daa_val = a + daa_adj;
    end else begin
      if (op.flags.carry) begin
        daa_adj = daa_adj | cpualu_pkg::DAA_HI_ADJ;
      end
      if (op.flags.half) begin
        daa_adj = daa_adj | cpualu_pkg::DAA_LO_ADJ;
      end
      daa_val = a - daa_adj;
    end
  end

  // Result and flag select by operation.
  always_comb begin
    res.result      = 16'h0000;
    res.writes_back = 1'b1;
    res.flags       = op.flags;
    case (op.command)
      cpualu_pkg::CMD_ADD, cpualu_pkg::CMD_ADC: begin
        res.result         = {8'h00, add_sum[7:0]};
        res.flags.zero     = (add_sum[7:0] == 8'h00);
        res.flags.subtract = 1'b0;
        res.flags.half     = add_nib[4];
        res.flags.carry    = add_sum[8];
      end
      cpualu_pkg::CMD_SUB, cpualu_pkg::CMD_SBC, cpualu_pkg::CMD_CP: begin
        res.result         = {8'h00, sub_diff[7:0]};
        res.writes_back    = (op.command != cpualu_pkg::CMD_CP);
        res.flags.zero     = (sub_diff[7:0] == 8'h00);
        res.flags.subtract = 1'b1;
        res.flags.half     = sub_nib[4];
        res.flags.carry    = sub_diff[8];
      end
      cpualu_pkg::CMD_AND: begin
        res.result = {8'h00, a & b};
        res.flags  = '{zero: ((a & b) == 8'h00), subtract: 1'b0, half: 1'b1, carry: 1'b0};
      end
      cpualu_pkg::CMD_XOR: begin
        res.result = {8'h00, a ^ b};
        res.flags  = '{zero: ((a ^ b) == 8'h00), subtract: 1'b0, half: 1'b0, carry: 1'b0};
      end
      cpualu_pkg::CMD_OR: begin
        res.result = {8'h00, a | b};
        res.flags  = '{zero: ((a | b) == 8'h00), subtract: 1'b0, half: 1'b0, carry: 1'b0};
      end
      cpualu_pkg::CMD_INC: begin
        res.result         = {8'h00, a + 8'h01};
        res.flags.zero     = (a == 8'hFF);
        res.flags.subtract = 1'b0;
        res.flags.half     = (a[3:0] == 4'hF);
      end
      cpualu_pkg::CMD_DEC: begin
        res.result         = {8'h00, a - 8'h01};
        res.flags.zero     = (a == 8'h01);
        res.flags.subtract = 1'b1;
        res.flags.half     = (a[3:0] == 4'h0);
      end
      cpualu_pkg::CMD_RLC, cpualu_pkg::CMD_RLCA: begin
        res.result      = {8'h00, a[6:0], a[7]};
        res.flags.carry = a[7];
      end
      cpualu_pkg::CMD_RRC, cpualu_pkg::CMD_RRCA: begin
        res.result      = {8'h00, a[0], a[7:1]};
        res.flags.carry = a[0];
      end
      cpualu_pkg::CMD_RL, cpualu_pkg::CMD_RLA: begin
        res.result      = {8'h00, a[6:0], op.flags.carry};
        res.flags.carry = a[7];
      end
      cpualu_pkg::CMD_RR, cpualu_pkg::CMD_RRA: begin
        res.result      = {8'h00, op.flags.carry, a[7:1]};
        res.flags.carry = a[0];
      end
      cpualu_pkg::CMD_SLA: begin
        res.result      = {8'h00, a[6:0], 1'b0};
        res.flags.carry = a[7];
      end
      cpualu_pkg::CMD_SRA: begin
        res.result      = {8'h00, a[7], a[7:1]};
        res.flags.carry = a[0];
      end
      cpualu_pkg::CMD_SWAP: begin
        res.result      = {8'h00, a[3:0], a[7:4]};
        res.flags.carry = 1'b0;
      end
      cpualu_pkg::CMD_SRL: begin
        res.result      = {8'h00, 1'b0, a[7:1]};
        res.flags.carry = a[0];
      end
      cpualu_pkg::CMD_BIT: begin
        res.result         = {8'h00, a};
        res.writes_back    = 1'b0;
        res.flags.zero     = ((a & bit_mask) == 8'h00);
        res.flags.subtract = 1'b0;
        res.flags.half     = 1'b1;
      end
      cpualu_pkg::CMD_RES: begin
        res.result = {8'h00, a & ~bit_mask};
      end
      cpualu_pkg::CMD_SET: begin
        res.result = {8'h00, a | bit_mask};
      end
      cpualu_pkg::CMD_DAA: begin
        res.result      = {8'h00, daa_val};
        res.flags.zero  = (daa_val == 8'h00);
        res.flags.half  = 1'b0;
        res.flags.carry = daa_carry;
      end
      cpualu_pkg::CMD_CPL: begin
        res.result         = {8'h00, ~a};
        res.flags.subtract = 1'b1;
        res.flags.half     = 1'b1;
      end
      cpualu_pkg::CMD_SCF: begin
        res.writes_back    = 1'b0;
        res.flags.subtract = 1'b0;
        res.flags.half     = 1'b0;
        res.flags.carry    = 1'b1;
      end
      cpualu_pkg::CMD_CCF: begin
        res.writes_back    = 1'b0;
        res.flags.subtract = 1'b0;
        res.flags.half     = 1'b0;
        res.flags.carry    = ~op.flags.carry;
      end
      cpualu_pkg::CMD_ADD16: begin
        res.result         = w_sum[15:0];
        res.flags.subtract = 1'b0;
        res.flags.half     = w_low[12];
        res.flags.carry    = w_sum[16];
      end
      cpualu_pkg::CMD_ADDSP: begin
        res.result = sp_sum;
        res.flags  = '{zero: 1'b0, subtract: 1'b0, half: sp_nib[4], carry: sp_byte[8]};
      end
      cpualu_pkg::CMD_INC16: begin
        res.result = op.wide_a + 16'h0001;
      end
      cpualu_pkg::CMD_DEC16: begin
        res.result = op.wide_a - 16'h0001;
      end
      default: begin
        res.writes_back = 1'b0;
      end
    endcase

    // Common flag rules for the prefixed shifts and the accumulator rotates.
    case (op.command)
      cpualu_pkg::CMD_RLC, cpualu_pkg::CMD_RRC, cpualu_pkg::CMD_RL, cpualu_pkg::CMD_RR,
      cpualu_pkg::CMD_SLA, cpualu_pkg::CMD_SRA, cpualu_pkg::CMD_SWAP,
      cpualu_pkg::CMD_SRL: begin
        res.flags.zero     = (res.result[7:0] == 8'h00);
        res.flags.subtract = 1'b0;
        res.flags.half     = 1'b0;
      end
      cpualu_pkg::CMD_RLCA, cpualu_pkg::CMD_RRCA, cpualu_pkg::CMD_RLA,
      cpualu_pkg::CMD_RRA: begin
        res.flags.zero     = 1'b0;
        res.flags.subtract = 1'b0;
        res.flags.half     = 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cpualu_pkg::*;

  // Run sizing and limits.
  localparam int          RANDOM_OPS    = 2000;
  localparam int          DRAIN_CYCLES  = 6;
  localparam int          RUN_LIMIT     = 400000;
  localparam int          MAX_REPORTED  = 10;
  localparam int          GAP_MAX       = 17;
  localparam logic [5:0]  CMD_FIELD_MAX = '1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [5:0]  in_command = '0;
  logic [7:0]  in_operand_a = '0;
  logic [7:0]  in_operand_b = '0;
  logic [2:0]  in_bit_index = '0;
  logic [15:0] in_wide_a = '0;
  logic [15:0] in_wide_b = '0;
  logic        in_zero_in = 1'b0;
  logic        in_subtract_in = 1'b0;
  logic        in_half_in = 1'b0;
  logic        in_carry_in = 1'b0;
  logic        out_valid;
  logic [15:0] out_result;
  logic        out_writes_back;
  logic        out_zero_out;
  logic        out_subtract_out;
  logic        out_half_out;
  logic        out_carry_out;

  op_t  op_backlog[$];
  res_t results_due[$];
  op_t  op_on_bus = '0;
  int   gap_left = 0;
  bit   burst_mode = 1'b0;
  int   ops_sent = 0;
  int   undefined_sent = 0;
  int   results_checked = 0;
  int   mismatches = 0;
  int   cycle_count = 0;

  cpu_alu_with_flags_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .in_bit_index     (in_bit_index),
    .in_wide_a        (in_wide_a),
    .in_wide_b        (in_wide_b),
    .in_zero_in       (in_zero_in),
    .in_subtract_in   (in_subtract_in),
    .in_half_in       (in_half_in),
    .in_carry_in      (in_carry_in),
    .out_valid        (out_valid),
    .out_result       (out_result),
    .out_writes_back  (out_writes_back),
    .out_zero_out     (out_zero_out),
    .out_subtract_out (out_subtract_out),
    .out_half_out     (out_half_out),
    .out_carry_out    (out_carry_out)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Computes the result and new flags that one operation should produce.
  function automatic res_t alu_outcome(op_t op);
    res_t        r;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  rb;
    logic        cin;
    logic        cy;
    logic [4:0]  nib5;
    logic [8:0]  sum9;
    logic [12:0] sum13;
    logic [16:0] sum17;
    a = op.operand_a;
    b = op.operand_b;
    r.result = '0;
    r.writes_back = 1'b1;
    r.flags = op.flags;
    case (op.command)
      CMD_ADD, CMD_ADC: begin
        cin = (op.command == CMD_ADC) && op.flags.carry;
        nib5 = a[3:0] + b[3:0] + cin;
        sum9 = a + b + cin;
        r.result = {8'h00, sum9[7:0]};
        r.flags.zero = (sum9[7:0] == 8'h00);
        r.flags.subtract = 1'b0;
        r.flags.half = nib5[4];
        r.flags.carry = sum9[8];
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        // The borrow shows up as the bit above the operand width.
        cin = (op.command == CMD_SBC) && op.flags.carry;
        nib5 = {1'b0, a[3:0]} - b[3:0] - cin;
        sum9 = {1'b0, a} - b - cin;
        r.result = {8'h00, sum9[7:0]};
        r.writes_back = (op.command != CMD_CP);
        r.flags.zero = (sum9[7:0] == 8'h00);
        r.flags.subtract = 1'b1;
        r.flags.half = nib5[4];
        r.flags.carry = sum9[8];
      end
      CMD_AND, CMD_XOR, CMD_OR: begin
        if (op.command == CMD_AND) begin
          rb = a & b;
        end else if (op.command == CMD_XOR) begin
          rb = a ^ b;
        end else begin
          rb = a | b;
        end
        r.result = {8'h00, rb};
        r.flags.zero = (rb == 8'h00);
        r.flags.subtract = 1'b0;
        r.flags.half = (op.command == CMD_AND);
        r.flags.carry = 1'b0;
      end
      CMD_INC, CMD_DEC: begin
        rb = (op.command == CMD_INC) ? a + 8'h01 : a - 8'h01;
        r.result = {8'h00, rb};
        r.flags.zero = (rb == 8'h00);
        r.flags.subtract = (op.command == CMD_DEC);
        r.flags.half = (op.command == CMD_INC) ? (a[3:0] == 4'hF) : (a[3:0] == 4'h0);
      end
      CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SWAP, CMD_SRL,
      CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA: begin
        cy = op.flags.carry;
        rb = a;
        case (op.command)
          CMD_RLC, CMD_RLCA: begin
            rb = {a[6:0], a[7]};
            cy = a[7];
          end
          CMD_RRC, CMD_RRCA: begin
            rb = {a[0], a[7:1]};
            cy = a[0];
          end
          CMD_RL, CMD_RLA: begin
            rb = {a[6:0], op.flags.carry};
            cy = a[7];
          end
          CMD_RR, CMD_RRA: begin
            rb = {op.flags.carry, a[7:1]};
            cy = a[0];
          end
          CMD_SLA: begin
            rb = {a[6:0], 1'b0};
            cy = a[7];
          end
          CMD_SRA: begin
            rb = {a[7], a[7:1]};
            cy = a[0];
          end
          CMD_SWAP: begin
            rb = {a[3:0], a[7:4]};
            cy = 1'b0;
          end
          default: begin
            rb = {1'b0, a[7:1]};
            cy = a[0];
          end
        endcase
        r.result = {8'h00, rb};
        // Accumulator rotates always clear Z; the prefixed shifts test the result.
        r.flags.zero = (op.command >= CMD_RLCA) ? 1'b0 : (rb == 8'h00);
        r.flags.subtract = 1'b0;
        r.flags.half = 1'b0;
        r.flags.carry = cy;
      end
      CMD_BIT: begin
        r.result = {8'h00, a};
        r.writes_back = 1'b0;
        r.flags.zero = ~a[op.bit_index];
        r.flags.subtract = 1'b0;
        r.flags.half = 1'b1;
      end
      CMD_RES: r.result = {8'h00, a & ~(8'h01 << op.bit_index)};
      CMD_SET: r.result = {8'h00, a | (8'h01 << op.bit_index)};
      CMD_DAA: begin
        // Decimal adjust looks at the byte as it was before any correction.
        rb = a;
        if (!op.flags.subtract) begin
          if (op.flags.carry || a > DAA_LIMIT) begin
            rb = rb + DAA_HI_ADJ;
            r.flags.carry = 1'b1;
          end
          if (op.flags.half || a[3:0] > DAA_NIB) begin
            rb = rb + DAA_LO_ADJ;
          end
        end else begin
          if (op.flags.carry) begin
            rb = rb - DAA_HI_ADJ;
          end
          if (op.flags.half) begin
            rb = rb - DAA_LO_ADJ;
          end
        end
        r.result = {8'h00, rb};
        r.flags.zero = (rb == 8'h00);
        r.flags.half = 1'b0;
      end
      CMD_CPL: begin
        r.result = {8'h00, ~a};
        r.flags.subtract = 1'b1;
        r.flags.half = 1'b1;
      end
      CMD_SCF, CMD_CCF: begin
        r.writes_back = 1'b0;
        r.flags.subtract = 1'b0;
        r.flags.half = 1'b0;
        r.flags.carry = (op.command == CMD_SCF) ? 1'b1 : ~op.flags.carry;
      end
      CMD_ADD16: begin
        sum13 = op.wide_a[11:0] + op.wide_b[11:0];
        sum17 = op.wide_a + op.wide_b;
        r.result = sum17[15:0];
        r.flags.subtract = 1'b0;
        r.flags.half = sum13[12];
        r.flags.carry = sum17[16];
      end
      CMD_ADDSP: begin
        // Flags come from the unsigned low-byte add; the sum uses the signed offset.
        nib5 = op.wide_a[3:0] + b[3:0];
        sum9 = op.wide_a[7:0] + b;
        r.result = op.wide_a + {{8{b[7]}}, b};
        r.flags.zero = 1'b0;
        r.flags.subtract = 1'b0;
        r.flags.half = nib5[4];
        r.flags.carry = sum9[8];
      end
      CMD_INC16: r.result = op.wide_a + 16'h0001;
      CMD_DEC16: r.result = op.wide_a - 16'h0001;
      default: r.writes_back = 1'b0;
    endcase
    return r;
  endfunction

  // Byte with a bias toward nibble and sign boundaries.
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 7))
        0: v = 8'h00;
        1: v = 8'h01;
        2: v = 8'h0F;
        3: v = 8'h10;
        4: v = 8'h7F;
        5: v = 8'h80;
        6: v = 8'h99;
        default: v = 8'hFF;
      endcase
    end
    return v;
  endfunction

  // Word with a bias toward the half-carry and carry boundaries.
  function automatic logic [15:0] pick_word();
    logic [15:0] v;
    v = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 7))
        0: v = 16'h0000;
        1: v = 16'h0001;
        2: v = 16'h00FF;
        3: v = 16'h0FFF;
        4: v = 16'h1000;
        5: v = 16'h7FFF;
        6: v = 16'h8000;
        default: v = 16'hFFFF;
      endcase
    end
    return v;
  endfunction

  function automatic op_t make_op(logic [5:0] cmd, logic [7:0] a, logic [7:0] b,
                                  logic [2:0] bi, logic [15:0] wa, logic [15:0] wb,
                                  logic [3:0] fl);
    op_t op;
    op.command = cmd;
    op.operand_a = a;
    op.operand_b = b;
    op.bit_index = bi;
    op.wide_a = wa;
    op.wide_b = wb;
    op.flags = flags_t'(fl);
    return op;
  endfunction

  // Driver: presents one operation beat at a time with random gaps between beats.
  always @(posedge clk) begin
    op_t next_op;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        results_due.push_back(alu_outcome(op_on_bus));
        ops_sent++;
        if (op_on_bus.command > CMD_DEC16) begin
          undefined_sent++;
        end
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (op_backlog.size() != 0) begin
          next_op = op_backlog.pop_front();
          op_on_bus <= next_op;
          in_command <= next_op.command;
          in_operand_a <= next_op.operand_a;
          in_operand_b <= next_op.operand_b;
          in_bit_index <= next_op.bit_index;
          in_wide_a <= next_op.wide_a;
          in_wide_b <= next_op.wide_b;
          in_zero_in <= next_op.flags.zero;
          in_subtract_in <= next_op.flags.subtract;
          in_half_in <= next_op.flags.half;
          in_carry_in <= next_op.flags.carry;
          start <= 1'b1;
          // Alternate between back-to-back bursts and randomly spaced beats.
          if ($urandom_range(0, 15) == 0) begin
            burst_mode = !burst_mode;
          end
          gap_left <= burst_mode ? 0 : $urandom_range(0, GAP_MAX);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
          $display("tb_top: result %h with no operation outstanding", out_result);
        end
      end else begin
        want = results_due.pop_front();
        results_checked++;
        if (out_result !== want.result || out_writes_back !== want.writes_back ||
            out_zero_out !== want.flags.zero || out_subtract_out !== want.flags.subtract ||
            out_half_out !== want.flags.half || out_carry_out !== want.flags.carry) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED) begin
            $display("tb_top: mismatch on result %0d: exp r=%h wb=%b znhc=%b%b%b%b",
                     results_checked, want.result, want.writes_back, want.flags.zero,
                     want.flags.subtract, want.flags.half, want.flags.carry);
            $display("tb_top:                      got r=%h wb=%b znhc=%b%b%b%b",
                     out_result, out_writes_back, out_zero_out, out_subtract_out,
                     out_half_out, out_carry_out);
          end
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    op_t item;
    logic [5:0] cmd;
    // Every operation once, alternating all-zero and all-one operands and flags.
    for (int k = CMD_ADD; k <= CMD_DEC16; k++) begin
      if (k % 2 == 1) begin
        op_backlog.push_back(make_op(6'(k), 8'hFF, 8'hFF, 3'h7, 16'hFFFF, 16'hFFFF, 4'hF));
      end else begin
        op_backlog.push_back(make_op(6'(k), 8'h00, 8'h00, 3'h0, 16'h0000, 16'h0000, 4'h0));
      end
    end
    // Undefined code, half and full carries, borrows, equal compare, decimal adjust
    // in both directions, negative stack offset and 16-bit wrap.
    op_backlog.push_back(make_op(CMD_FIELD_MAX, 8'hFF, 8'hFF, 3'h7, 16'hFFFF, 16'hFFFF, 4'hF));
    op_backlog.push_back(make_op(CMD_ADD, 8'h0F, 8'h01, 3'h0, 16'h0000, 16'h0000, 4'h0));
    op_backlog.push_back(make_op(CMD_ADD, 8'hFF, 8'h01, 3'h0, 16'h0000, 16'h0000, 4'h0));
    op_backlog.push_back(make_op(CMD_SUB, 8'h10, 8'h01, 3'h0, 16'h0000, 16'h0000, 4'h0));
    op_backlog.push_back(make_op(CMD_CP, 8'h5A, 8'h5A, 3'h0, 16'h0000, 16'h0000, 4'h0));
    op_backlog.push_back(make_op(CMD_DAA, 8'h9A, 8'h00, 3'h0, 16'h0000, 16'h0000, 4'h0));
    op_backlog.push_back(make_op(CMD_DAA, 8'h00, 8'h00, 3'h0, 16'h0000, 16'h0000, 4'h7));
    op_backlog.push_back(make_op(CMD_ADDSP, 8'h00, 8'h80, 3'h0, 16'h00FF, 16'h0000, 4'hF));
    op_backlog.push_back(make_op(CMD_ADD16, 8'h00, 8'h00, 3'h0, 16'h0FFF, 16'h0001, 4'h8));
    op_backlog.push_back(make_op(CMD_BIT, 8'h80, 8'h00, 3'h7, 16'h0000, 16'h0000, 4'h0));

    // Random operations, with a small share of undefined codes.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        cmd = 6'($urandom_range(int'(CMD_DEC16) + 1, int'(CMD_FIELD_MAX)));
      end else begin
        cmd = 6'($urandom_range(int'(CMD_ADD), int'(CMD_DEC16)));
      end
      item = make_op(cmd, pick_byte(), pick_byte(), 3'($urandom), pick_word(), pick_word(),
                     4'($urandom));
      op_backlog.push_back(item);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (op_backlog.size() != 0 || start || results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d operations applied (%0d with undefined codes), %0d results checked",
             ops_sent, undefined_sent, results_checked);
    $display("tb_top: %0d mismatches over all ALU, shift, bit and 16-bit operations",
             mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/cpualu_pkg.sv
hdl/cpualu_exec.sv
hdl/cpu_alu_with_flags_core.sv
tb/sv/tb_top.sv
